// File: design/tct_pkg.sv
`default_nettype none

package tct_pkg;

   localparam int CMD_W    = 2;
   localparam int TMO_W    = 32;
   localparam int TYPE_W   = 3;
   localparam int TSC_W    = 64;
   localparam int STAT_W   = 3;
   localparam int FREQ_W   = 36;
   localparam int NUM_FREQ = 4;
   localparam int IDX_W    = 2;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 36'd1000000000;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd3;

   localparam logic [TYPE_W-1:0] TYPE_UNDEF = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_HPET0 = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_HPET1 = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_PIT   = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_PM    = 3'd4;
   localparam logic [TYPE_W-1:0] TYPE_RTC   = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EXPIRED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_INVAL   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_STATE   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_UNSUP   = 3'd4;
   localparam logic [STAT_W-1:0] STAT_UNDEF   = 3'd5;

   typedef logic [TSC_W-1:0]  tsc_type;
   typedef logic [FREQ_W-1:0] freq_type;

endpackage

`default_nettype wire

// File: design/tct_req_if.sv
`default_nettype none

interface tct_req_if;
   import tct_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [TMO_W-1:0]  limit_ms;
   logic [TYPE_W-1:0]        tick_source;
   logic [TSC_W-1:0]         tsc_now;

   modport source (output valid, command, limit_ms, tick_source, tsc_now, input ready);
   modport sink   (input valid, command, limit_ms, tick_source, tsc_now, output ready);
endinterface

`default_nettype wire

// File: design/tct_rsp_if.sv
`default_nettype none

interface tct_rsp_if;
   import tct_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

// File: design/tct_div.sv
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient.
module tct_div (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire tct_pkg::tsc_type  dividend,
   input  wire tct_pkg::freq_type divisor,
   output logic                  done,
   output tct_pkg::tsc_type      quotient
);
   import tct_pkg::*;

   localparam int CNT_W = $clog2(TSC_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   tsc_type           quot_ff, quot_in;
   freq_type          rem_ff, rem_in;
   freq_type          div_ff, div_in;

   logic [FREQ_W:0]   trial;
   logic [FREQ_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quot_ff[TSC_W-1]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(TSC_W - 1);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[TSC_W-2:0], ge};
         rem_in  = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

`default_nettype wire

// File: design/timeout_countdown_timer.sv
`default_nettype none

// One-shot millisecond timeout timer. Each request item carries a command
// (start, poll, stop, reset), a timeout, a timer type and the current
// timestamp counter value; each request returns exactly one status item.
// Start and stop items, and polls of an idle or already expired timer, go
// from decode straight to the output register. A poll of a running timer
// goes through these steps in order: decode, form the timestamp delta, scale
// it by 1000 with shifts and subtracts (S_MUL_A, S_MUL_B), start the radix-2
// divider, wait in the divider that divides by the selected frequency until
// it finishes, update the remaining time and load the output register. A
// reset item of a running timer also stops and restarts the timer before the
// output register is loaded. The block takes one request at a time;
// req_if.ready is high only when it is idle. The status sits in an output
// register, so a new request is accepted while the previous status still
// waits to be taken. The user must set frequencies per timer type through
// the csr_ write port only while the block is idle; the block itself does not
// enforce this.
module timeout_countdown_timer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tct_req_if.sink                            req_if,
   tct_rsp_if.source                          rsp_if,
   input  wire logic                          csr_write_enable,
   input  wire logic [tct_pkg::IDX_W-1:0]     csr_index,
   input  wire tct_pkg::freq_type             csr_write_data
);
   import tct_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_DELTA    = 4'd2;
   localparam logic [3:0] S_MUL_A    = 4'd3;
   localparam logic [3:0] S_MUL_B    = 4'd4;
   localparam logic [3:0] S_DIV_GO   = 4'd5;
   localparam logic [3:0] S_DIV_WAIT = 4'd6;
   localparam logic [3:0] S_SUB      = 4'd7;
   localparam logic [3:0] S_TAIL     = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   // Timer type check for start: ok, unsupported (rtc) or undefined.
   function automatic logic [STAT_W-1:0] type_check(input logic [TYPE_W-1:0] t);
      logic [STAT_W-1:0] s;
      case (t) inside
         TYPE_HPET0, TYPE_HPET1, TYPE_PIT, TYPE_PM: s = STAT_OK;
         TYPE_RTC:                                  s = STAT_UNSUP;
         default:                                   s = STAT_UNDEF;
      endcase
      return s;
   endfunction

   logic [3:0]              state_ff, state_in;

   // latched request item
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [TMO_W-1:0]        tmo_ff, tmo_in;
   logic [TYPE_W-1:0]       type_ff, type_in;
   tsc_type                 tsc_ff, tsc_in;

   // timer state
   logic                    running_ff, running_in;
   logic                    expired_ff, expired_in;
   tsc_type                 remaining_ff, remaining_in;
   logic [TYPE_W-1:0]       active_type_ff, active_type_in;
   tsc_type                 last_tsc_ff, last_tsc_in;

   // poll datapath
   tsc_type                 ticks_ff, ticks_in;
   tsc_type                 prod_ff, prod_in;
   logic [STAT_W-1:0]       res_ff, res_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;

   freq_type                freq_ff [NUM_FREQ];
   logic [IDX_W-1:0]        freq_sel;

   logic                    div_start;
   logic                    div_done;
   tsc_type                 div_quot;
   tsc_type                 rem_new;
   logic                    rem_expired;
   logic [STAT_W-1:0]       tc;

   assign freq_sel    = active_type_ff[IDX_W-1:0] - 1'b1;
   assign rem_new     = remaining_ff - div_quot;
   assign rem_expired = (rem_new == '0) || rem_new[TSC_W-1];
   assign tc          = type_check(type_ff);

   tct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (freq_ff[freq_sel]),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      tmo_in         = tmo_ff;
      type_in        = type_ff;
      tsc_in         = tsc_ff;
      running_in     = running_ff;
      expired_in     = expired_ff;
      remaining_in   = remaining_ff;
      active_type_in = active_type_ff;
      last_tsc_in    = last_tsc_ff;
      ticks_in       = ticks_ff;
      prod_in        = prod_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      div_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // capture the request item
            if (req_if.valid) begin
               cmd_in   = req_if.command;
               tmo_in   = req_if.limit_ms;
               type_in  = req_if.tick_source;
               tsc_in   = req_if.tsc_now;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            unique case (cmd_ff) inside
               CMD_START: begin
                  if (tmo_ff[TMO_W-1]) begin
                     res_in = STAT_INVAL;
                  end else if (running_ff || expired_ff) begin
                     res_in = STAT_STATE;
                  end else if (tc != STAT_OK) begin
                     res_in = tc;
                  end else begin
                     // arm the timer
                     remaining_in   = {{(TSC_W-TMO_W){1'b0}}, tmo_ff};
                     active_type_in = type_ff;
                     last_tsc_in    = tsc_ff;
                     running_in     = 1'b1;
                     res_in         = STAT_OK;
                  end
               end
               CMD_STOP: begin
                  running_in     = 1'b0;
                  expired_in     = 1'b0;
                  active_type_in = TYPE_UNDEF;
                  remaining_in   = '0;
                  res_in         = STAT_OK;
               end
               CMD_POLL, CMD_RESET: begin
                  if (!running_ff) begin
                     // not running: report and leave everything alone
                     res_in = STAT_STATE;
                  end else if (expired_ff) begin
                     res_in = STAT_EXPIRED;
                     if (cmd_ff == CMD_RESET) begin
                        state_in = S_TAIL;
                     end
                  end else begin
                     state_in = S_DELTA;
                  end
               end
               default: begin
                  res_in = STAT_OK;
               end
            endcase
         end
         S_DELTA: begin
            ticks_in = tsc_ff - last_tsc_ff;
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            // ticks * 1000 = ticks*1024 - ticks*16 - ticks*8, modulo 2^64
            prod_in  = (ticks_ff << 10) - (ticks_ff << 4);
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            prod_in  = prod_ff - (ticks_ff << 3);
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            // subtract elapsed ms, latch expiry at or below zero
            remaining_in = rem_new;
            last_tsc_in  = tsc_ff;
            expired_in   = rem_expired;
            res_in       = rem_expired ? STAT_EXPIRED : STAT_OK;
            state_in     = (cmd_ff == CMD_RESET) ? S_TAIL : S_DONE;
         end
         S_TAIL: begin
            // reset command: stop, then start; a start error overrides the poll status
            running_in     = 1'b0;
            expired_in     = 1'b0;
            active_type_in = TYPE_UNDEF;
            remaining_in   = '0;
            if (tmo_ff[TMO_W-1]) begin
               res_in = STAT_INVAL;
            end else if (tc != STAT_OK) begin
               res_in = tc;
            end else begin
               remaining_in   = {{(TSC_W-TMO_W){1'b0}}, tmo_ff};
               active_type_in = type_ff;
               last_tsc_in    = tsc_ff;
               running_in     = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         running_ff     <= 1'b0;
         expired_ff     <= 1'b0;
         remaining_ff   <= '0;
         active_type_ff <= TYPE_UNDEF;
         last_tsc_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         running_ff     <= running_in;
         expired_ff     <= expired_in;
         remaining_ff   <= remaining_in;
         active_type_ff <= active_type_in;
         last_tsc_ff    <= last_tsc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      tmo_ff        <= tmo_in;
      type_ff       <= type_in;
      tsc_ff        <= tsc_in;
      ticks_ff      <= ticks_in;
      prod_ff       <= prod_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
   end

   // frequency registers, one per supported timer type
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FREQ; i++) begin
            freq_ff[i] <= FREQ_RESET;
         end
      end else if (csr_write_enable) begin
         freq_ff[csr_index] <= csr_write_data;
      end
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
endmodule

`default_nettype wire
